FILE: design/dlq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_pkg
// Shared types and constants for the distance LIS query core.
// ----------------------------------------------------------------------------
package dlq_pkg;

   // Payload widths
   localparam int REQ_TYPE_W = 2;
   localparam int VALUE_W    = 32;
   localparam int DIST_W     = 33;
   localparam int LEN_W      = 9;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd2;

   // Query engine states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_PROBE,
      ST_WRITE,
      ST_DONE
   } dlq_state_type;

   // Engine status towards the top level
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [LEN_W-1:0] lis_length;
   } dlq_qstat_type;

endpackage

FILE: design/dlq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_req_if
// Request channel: clear, append or query beats with valid/ready.
// ----------------------------------------------------------------------------
interface dlq_req_if import dlq_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_W-1:0]     req_type;
   logic signed [VALUE_W-1:0] element_value;
   logic signed [VALUE_W-1:0] query_point;

   modport source (output valid, req_type, element_value, query_point, input ready);
   modport sink   (input valid, req_type, element_value, query_point, output ready);
endinterface

FILE: design/dlq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_rsp_if
// Response channel: one LIS length beat per query.
// ----------------------------------------------------------------------------
interface dlq_rsp_if import dlq_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] lis_length;

   modport source (output valid, lis_length, input ready);
   modport sink   (input valid, lis_length, output ready);
endinterface

FILE: design/dlq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_store
// Sequence store: value memory with fill count, append and clear handling,
// and one registered read port for the query engine.
// ----------------------------------------------------------------------------
module dlq_store import dlq_pkg::*; #(
   parameter  int MAX_LEN = 256,
   localparam int AW      = $clog2(MAX_LEN),
   localparam int CW      = $clog2(MAX_LEN + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      append,
   input  logic signed [VALUE_W-1:0] element_value,
   input  logic [AW-1:0]             rd_addr,
   output logic signed [VALUE_W-1:0] rd_data,
   output logic [CW-1:0]             stored_count
);

   logic signed [VALUE_W-1:0] value_mem [MAX_LEN];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      wr_en;

   // Appends beyond capacity are dropped
   assign wr_en = append && (count_ff < CW'(MAX_LEN));

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Value memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[AW'(count_ff)] <= element_value;
      end
      rd_data_ff <= value_mem[rd_addr];
   end

   assign rd_data      = rd_data_ff;
   assign stored_count = count_ff;

endmodule

FILE: design/dlq_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlq_search
// Query engine: walks the stored values, forms each distance and places it
// in the tails memory by a binary search, one probe per cycle.
// ----------------------------------------------------------------------------
module dlq_search import dlq_pkg::*; #(
   parameter  int MAX_LEN = 256,
   localparam int AW      = $clog2(MAX_LEN),
   localparam int CW      = $clog2(MAX_LEN + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [VALUE_W-1:0] query_point,
   input  logic [CW-1:0]             stored_count,
   output logic [AW-1:0]             val_rd_addr,
   input  logic signed [VALUE_W-1:0] val_rd_data,
   input  logic                      take,
   output dlq_qstat_type             qstat
);

   dlq_state_type state_ff, state_in;

   logic signed [VALUE_W-1:0] k_ff, k_in;
   logic [DIST_W-1:0]         d_ff, d_in;
   logic [CW-1:0]             i_ff, i_in;
   logic [CW-1:0]             len_ff, len_in;
   logic [CW-1:0]             lo_ff, lo_in;
   logic [CW-1:0]             hi_ff, hi_in;
   logic [AW-1:0]             mid_ff, mid_in;

   // Tails memory
   logic [DIST_W-1:0] tails_mem [MAX_LEN];
   logic [DIST_W-1:0] tail_rd_ff;
   logic [AW-1:0]     tail_rd_addr;
   logic              tail_we;

   // Datapath helpers
   logic signed [DIST_W-1:0] diff;
   logic [DIST_W-1:0]        abs_diff;
   logic                     tail_lt;
   logic [CW-1:0]            lo_step;
   logic [CW-1:0]            hi_step;
   logic [CW:0]              mid_sum;
   logic [CW-1:0]            len_half;
   logic [CW-1:0]            i_inc;
   logic                     more_elems;

   // Distance |v - k| as an exact 33-bit magnitude
   assign diff     = DIST_W'(val_rd_data) - DIST_W'(k_ff);
   assign abs_diff = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

   // One binary search step on the registered probe
   assign tail_lt    = tail_rd_ff < d_ff;
   assign lo_step    = tail_lt ? (CW'(mid_ff) + CW'(1)) : lo_ff;
   assign hi_step    = tail_lt ? hi_ff : CW'(mid_ff);
   assign mid_sum    = {1'b0, lo_step} + {1'b0, hi_step};
   assign len_half   = len_ff >> 1;
   assign i_inc      = i_ff + CW'(1);
   assign more_elems = i_inc < stored_count;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (stored_count == '0) ? ST_DONE : ST_DIST;
            end
         end
         ST_DIST: begin
            state_in = (len_ff == '0) ? ST_WRITE : ST_PROBE;
         end
         ST_PROBE: begin
            if (!(lo_step < hi_step)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = more_elems ? ST_DIST : ST_DONE;
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      k_in         = k_ff;
      d_in         = d_ff;
      i_in         = i_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      tail_rd_addr = mid_ff;
      tail_we      = 1'b0;
      val_rd_addr  = AW'(i_ff);
      case (state_ff)
         ST_IDLE: begin
            val_rd_addr = '0;
            if (start) begin
               k_in   = query_point;
               i_in   = '0;
               len_in = '0;
            end
         end
         ST_DIST: begin
            // Latch distance and issue the first probe at the middle
            d_in         = abs_diff;
            lo_in        = '0;
            hi_in        = len_ff;
            mid_in       = AW'(len_half);
            tail_rd_addr = AW'(len_half);
         end
         ST_PROBE: begin
            lo_in        = lo_step;
            hi_in        = hi_step;
            mid_in       = AW'(mid_sum >> 1);
            tail_rd_addr = AW'(mid_sum >> 1);
         end
         ST_WRITE: begin
            // Replace or extend the tails, fetch the next value
            tail_we = lo_ff < CW'(MAX_LEN);
            if ((lo_ff == len_ff) && (len_ff < CW'(MAX_LEN))) begin
               len_in = len_ff + CW'(1);
            end
            i_in        = i_inc;
            val_rd_addr = AW'(i_inc);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      d_ff   <= d_in;
      i_ff   <= i_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
   end

   // Tails memory: write in the write state only, so no same-entry overlap
   always_ff @(posedge clock) begin
      if (tail_we) begin
         tails_mem[AW'(lo_ff)] <= d_ff;
      end
      tail_rd_ff <= tails_mem[tail_rd_addr];
   end

   assign qstat.busy       = state_ff != ST_IDLE;
   assign qstat.done       = state_ff == ST_DONE;
   assign qstat.lis_length = LEN_W'(len_ff);

endmodule

FILE: design/distance_lis_query_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_lis_query_core
// Holds a sequence of signed values and answers queries for the length of
// the longest strictly increasing subsequence of distances to a point.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents                              Result
//  req_ch   in   req_type, element_value, query_point       -
//  rsp_ch   out  lis_length                                 one per query
//
//  A query places each value in the tails memory by a binary search of
//  about log2 of the current tails length probes, paced by the single
//  read port of the tails memory (one probe a cycle).
//  Reset clears the fill count and the engine; memories are not cleared.
//  The result register holds a beat while rsp_ch stalls; a finished query
//  waits in its done state and req_ch is not ready while a query runs.
// ----------------------------------------------------------------------------
module distance_lis_query_core import dlq_pkg::*; #(
   parameter int MAX_LEN = 256
) (
   input logic      clock,
   input logic      reset,
   dlq_req_if.sink   req_ch,
   dlq_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   logic                      req_beat;
   logic                      do_clear;
   logic                      do_append;
   logic                      do_query;
   logic                      take;
   logic [AW-1:0]             val_rd_addr;
   logic signed [VALUE_W-1:0] val_rd_data;
   logic [CW-1:0]             stored_count;
   dlq_qstat_type             qstat;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;

   // Request decode
   assign req_ch.ready = !qstat.busy;
   assign req_beat     = req_ch.valid && req_ch.ready;
   assign do_clear     = req_beat && (req_ch.req_type == REQ_CLEAR);
   assign do_append    = req_beat && (req_ch.req_type == REQ_APPEND);
   assign do_query     = req_beat && (req_ch.req_type == REQ_QUERY);

   dlq_store #(
      .MAX_LEN (MAX_LEN)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .clear         (do_clear),
      .append        (do_append),
      .element_value (req_ch.element_value),
      .rd_addr       (val_rd_addr),
      .rd_data       (val_rd_data),
      .stored_count  (stored_count)
   );

   dlq_search #(
      .MAX_LEN (MAX_LEN)
   ) u_search (
      .clock        (clock),
      .reset        (reset),
      .start        (do_query),
      .query_point  (req_ch.query_point),
      .stored_count (stored_count),
      .val_rd_addr  (val_rd_addr),
      .val_rd_data  (val_rd_data),
      .take         (take),
      .qstat        (qstat)
   );

   // Result register: loads when empty or being drained
   assign take = qstat.done && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = qstat.lis_length;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff <= rsp_len_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.lis_length = rsp_len_ff;

endmodule
